// File: design/pspa_pkg.sv
// Shared types and codes for the paged slot pool allocator.
package pspa_pkg;

   localparam int CSR_W       = 9;
   localparam int PAGE_OUT_W  = 4;
   localparam int SLOT_OUT_W  = 8;
   localparam int OBJ_OUT_W   = 13;
   localparam int OPEN_OUT_W  = 5;

   // Request codes.
   localparam logic [1:0] REQ_ALLOC   = 2'd0;
   localparam logic [1:0] REQ_FREE    = 2'd1;
   localparam logic [1:0] REQ_RELEASE = 2'd2;

   // Result status codes.
   localparam logic [1:0] STAT_OK          = 2'd0;
   localparam logic [1:0] STAT_NO_PAGES    = 2'd1;
   localparam logic [1:0] STAT_BAD_HANDLE  = 2'd2;
   localparam logic [1:0] STAT_DOUBLE_FREE = 2'd3;

   typedef struct packed {
      logic [1:0]            req_type;
      logic [PAGE_OUT_W-1:0] free_page;
      logic [SLOT_OUT_W-1:0] free_slot;
   } req_word_type;

   typedef struct packed {
      logic [PAGE_OUT_W-1:0] handle_page;
      logic [SLOT_OUT_W-1:0] handle_slot;
      logic [1:0]            status;
      logic [OBJ_OUT_W-1:0]  objects_in_use;
      logic [OPEN_OUT_W-1:0] pages_open;
   } rsp_word_type;

   typedef struct packed {
      logic done;
      logic found;
   } scan_status_type;

endpackage

// File: design/pspa_page_table.sv
// Per-page table (free-list head, used count, seed mark) with the first-fit page scan.
module pspa_page_table #(
   parameter int MAX_PAGES = 16,
   parameter int NW        = 9,
   parameter int PW        = 4,
   parameter int OW        = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     scan_start,
   input  logic [OW-1:0]            open_count,
   input  logic [NW-1:0]            n_eff,
   input  logic                     rd_en,
   input  logic [PW-1:0]            rd_page,
   input  logic                     wr_en,
   input  logic [PW-1:0]            wr_page,
   input  logic [NW-1:0]            wr_head,
   input  logic [NW-1:0]            wr_count,
   input  logic [NW-1:0]            wr_wm,
   output pspa_pkg::scan_status_type scan_status,
   output logic [PW-1:0]            scan_page,
   output logic [NW-1:0]            rd_head,
   output logic [NW-1:0]            rd_count,
   output logic [NW-1:0]            rd_wm
);

   logic [3*NW-1:0] page_mem [MAX_PAGES];
   logic [3*NW-1:0] rd_data_ff;

   logic            scanning_ff, scanning_in;
   logic [OW-1:0]   scan_ptr_ff, scan_ptr_in;
   logic            chk_valid_ff, chk_valid_in;
   logic [PW-1:0]   chk_page_ff, chk_page_in;

   logic            found;
   logic            exhausted;
   logic            issue;
   logic [PW-1:0]   rd_addr;

   assign rd_head  = rd_data_ff[3*NW-1:2*NW];
   assign rd_count = rd_data_ff[2*NW-1:NW];
   assign rd_wm    = rd_data_ff[NW-1:0];

   // The page read last cycle is being checked while the next one is read.
   assign found     = scanning_ff && chk_valid_ff && (rd_count < n_eff);
   assign exhausted = scanning_ff && !chk_valid_ff && (scan_ptr_ff >= open_count);
   assign issue     = scanning_ff && !found && (scan_ptr_ff < open_count);
   assign rd_addr   = issue ? PW'(scan_ptr_ff) : rd_page;

   assign scan_status.done  = found || exhausted;
   assign scan_status.found = found;
   assign scan_page         = chk_page_ff;

   always_comb begin
      scanning_in  = scanning_ff;
      scan_ptr_in  = scan_ptr_ff;
      chk_valid_in = 1'b0;
      chk_page_in  = chk_page_ff;
      if (scan_start) begin
         scanning_in = 1'b1;
         scan_ptr_in = '0;
      end else if (found || exhausted) begin
         scanning_in = 1'b0;
      end else if (issue) begin
         chk_valid_in = 1'b1;
         chk_page_in  = PW'(scan_ptr_ff);
         scan_ptr_in  = scan_ptr_ff + OW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scanning_ff  <= 1'b0;
         chk_valid_ff <= 1'b0;
      end else begin
         scanning_ff  <= scanning_in;
         chk_valid_ff <= chk_valid_in;
      end
      scan_ptr_ff <= scan_ptr_in;
      chk_page_ff <= chk_page_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         page_mem[wr_page] <= {wr_head, wr_count, wr_wm};
      end
      if (issue || rd_en) begin
         rd_data_ff <= page_mem[rd_addr];
      end
   end

endmodule

// File: design/pspa_slot_store.sv
// Per-slot store of next-free links and used flags, with lazy seeding above the page's seed mark.
module pspa_slot_store #(
   parameter int AW    = 12,
   parameter int DEPTH = 4096,
   parameter int NW    = 9,
   parameter int SW    = 8
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   input  logic [NW-1:0] wm_i,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_used,
   input  logic [NW-1:0] wr_link,
   output logic          used_o,
   output logic [NW-1:0] link_o,
   output logic          fresh_o
);

   logic [NW:0]   slot_mem [DEPTH];
   logic [NW:0]   rd_data_ff;
   logic [SW-1:0] rd_slot_ff;

   // Slots at or above the seed mark have not been handed out since the page
   // opened: they read as free, linked to the next slot up.
   assign fresh_o = NW'(rd_slot_ff) >= wm_i;
   assign link_o  = fresh_o ? NW'(rd_slot_ff) + NW'(1) : rd_data_ff[NW-1:0];
   assign used_o  = !fresh_o && rd_data_ff[NW];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= {wr_used, wr_link};
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
         rd_slot_ff <= rd_addr[SW-1:0];
      end
   end

endmodule

// File: design/paged_slot_pool_allocator.sv
// Top level of the paged slot pool allocator: request sequencer and result register.
// Usage:
//   A request word (allocate, free a handle, release all pages) enters on the
//   req_ channel; exactly one result word leaves on the rsp_ channel for each.
//   csr_wr_data sets the slots per page and is taken only while no page is open.
// Sequence, from acceptance to rsp_valid:
//   allocate: the page table is read one page a cycle from page 0 until a page
//   with room is found (else a new page is opened if one is left), then the slot
//   store is read and both memories are written back.
//   free: one read of both memories, one write-back (none on a double free), result
//   load; a handle outside the pool skips the reads and goes straight to the result load.
//   release all and unknown codes: straight to the result load.
//   One request is in flight at a time; req_stall is low while the sequencer is
//   idle, even if the previous result still waits in the output register.
// Reset clears the page count, object count and result valid flag and sets the
//   slots per page to 256. No memory is cleared: each page is reseeded lazily
//   when it opens, so the block is ready in the cycle after reset.
// While rsp_stall is high the result is held and the next result waits in the
//   sequencer, which then stalls the request channel.
module paged_slot_pool_allocator #(
   parameter int MAX_PAGES      = 16,
   parameter int SLOTS_PER_PAGE = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pspa_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pspa_pkg::rsp_word_type rsp_word,
   input  logic                  csr_wr_en,
   input  logic [pspa_pkg::CSR_W-1:0] csr_wr_data
);

   localparam int SLOT_CAP = (SLOTS_PER_PAGE < 256) ? SLOTS_PER_PAGE : 256;
   localparam int SW       = $clog2(SLOT_CAP);
   localparam int NW       = $clog2(SLOT_CAP + 1);
   localparam int PW       = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int OW       = $clog2(MAX_PAGES + 1);
   localparam int TW       = $clog2(MAX_PAGES * SLOT_CAP + 1);
   localparam int FW       = (OW > pspa_pkg::PAGE_OUT_W) ? OW : pspa_pkg::PAGE_OUT_W;
   localparam int AW       = PW + SW;
   localparam int DEPTH    = MAX_PAGES * (2 ** SW);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SCAN     = 3'd1;
   localparam logic [2:0] ST_POP_RD   = 3'd2;
   localparam logic [2:0] ST_POP_WB   = 3'd3;
   localparam logic [2:0] ST_FREE_CHK = 3'd4;
   localparam logic [2:0] ST_DONE     = 3'd5;

   logic [2:0]                   state_ff, state_in;
   pspa_pkg::req_word_type       req_ff, req_in;
   logic [OW-1:0]                open_ff, open_in;
   logic [TW-1:0]                total_ff, total_in;
   logic [pspa_pkg::CSR_W-1:0]   spp_ff, spp_in;
   logic [PW-1:0]                sel_page_ff, sel_page_in;
   logic                         new_page_ff, new_page_in;
   logic [1:0]                   status_ff, status_in;
   logic [PW-1:0]                hpage_ff, hpage_in;
   logic [SW-1:0]                hslot_ff, hslot_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   pspa_pkg::rsp_word_type       rsp_word_ff, rsp_word_in;

   logic [NW-1:0]                n_eff;
   logic                         free_bad;

   pspa_pkg::scan_status_type    scan_status;
   logic [PW-1:0]                scan_page;
   logic                         scan_start;
   logic                         pt_rd_en;
   logic [PW-1:0]                pt_rd_page;
   logic                         pt_wr_en;
   logic [PW-1:0]                pt_wr_page;
   logic [NW-1:0]                pt_wr_head, pt_wr_count, pt_wr_wm;
   logic [NW-1:0]                pt_rd_head, pt_rd_count, pt_rd_wm;

   logic [NW-1:0]                ent_head, ent_count, ent_wm;
   logic [NW-1:0]                pop_head;

   logic                         ss_rd_en;
   logic [AW-1:0]                ss_rd_addr;
   logic                         ss_wr_en;
   logic [AW-1:0]                ss_wr_addr;
   logic                         ss_wr_used;
   logic [NW-1:0]                ss_wr_link;
   logic                         ss_used;
   logic [NW-1:0]                ss_link;
   logic                         ss_fresh;

   // Effective slots per page: zero acts as one, and the value is capped.
   always_comb begin
      if (spp_ff == '0) begin
         n_eff = NW'(1);
      end else if (int'(spp_ff) > SLOT_CAP) begin
         n_eff = NW'(SLOT_CAP);
      end else begin
         n_eff = NW'(spp_ff);
      end
   end

   assign free_bad = (FW'(req_word.free_page) >= FW'(open_ff)) ||
                     ({1'b0, req_word.free_slot} >= pspa_pkg::CSR_W'(n_eff));

   // A freshly opened page has an empty entry that is written only at the end of the pop.
   assign ent_head  = new_page_ff ? '0 : pt_rd_head;
   assign ent_count = new_page_ff ? '0 : pt_rd_count;
   assign ent_wm    = new_page_ff ? '0 : pt_rd_wm;
   assign pop_head  = (ent_head >= n_eff) ? '0 : ent_head;

   pspa_page_table #(
      .MAX_PAGES (MAX_PAGES),
      .NW        (NW),
      .PW        (PW),
      .OW        (OW)
   ) u_page_table (
      .clock       (clock),
      .reset       (reset),
      .scan_start  (scan_start),
      .open_count  (open_ff),
      .n_eff       (n_eff),
      .rd_en       (pt_rd_en),
      .rd_page     (pt_rd_page),
      .wr_en       (pt_wr_en),
      .wr_page     (pt_wr_page),
      .wr_head     (pt_wr_head),
      .wr_count    (pt_wr_count),
      .wr_wm       (pt_wr_wm),
      .scan_status (scan_status),
      .scan_page   (scan_page),
      .rd_head     (pt_rd_head),
      .rd_count    (pt_rd_count),
      .rd_wm       (pt_rd_wm)
   );

   pspa_slot_store #(
      .AW    (AW),
      .DEPTH (DEPTH),
      .NW    (NW),
      .SW    (SW)
   ) u_slot_store (
      .clock   (clock),
      .rd_en   (ss_rd_en),
      .rd_addr (ss_rd_addr),
      .wm_i    (ent_wm),
      .wr_en   (ss_wr_en),
      .wr_addr (ss_wr_addr),
      .wr_used (ss_wr_used),
      .wr_link (ss_wr_link),
      .used_o  (ss_used),
      .link_o  (ss_link),
      .fresh_o (ss_fresh)
   );

   // Each request finishes its write-back before the next read is issued, so
   // no access to the same entry can overlap.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      open_in      = open_ff;
      total_in     = total_ff;
      spp_in       = spp_ff;
      sel_page_in  = sel_page_ff;
      new_page_in  = new_page_ff;
      status_in    = status_ff;
      hpage_in     = hpage_ff;
      hslot_in     = hslot_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      scan_start  = 1'b0;
      pt_rd_en    = 1'b0;
      pt_rd_page  = PW'(req_word.free_page);
      pt_wr_en    = 1'b0;
      pt_wr_page  = sel_page_ff;
      pt_wr_head  = '0;
      pt_wr_count = '0;
      pt_wr_wm    = '0;
      ss_rd_en    = 1'b0;
      ss_rd_addr  = {PW'(req_word.free_page), SW'(req_word.free_slot)};
      ss_wr_en    = 1'b0;
      ss_wr_addr  = {sel_page_ff, hslot_ff};
      ss_wr_used  = 1'b0;
      ss_wr_link  = '0;

      if (csr_wr_en && (open_ff == '0)) begin
         spp_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in      = req_word;
               status_in   = pspa_pkg::STAT_OK;
               hpage_in    = '0;
               hslot_in    = '0;
               new_page_in = 1'b0;
               case (req_word.req_type)
                  pspa_pkg::REQ_ALLOC: begin
                     scan_start = 1'b1;
                     state_in   = ST_SCAN;
                  end
                  pspa_pkg::REQ_FREE: begin
                     if (free_bad) begin
                        status_in = pspa_pkg::STAT_BAD_HANDLE;
                        state_in  = ST_DONE;
                     end else begin
                        pt_rd_en = 1'b1;
                        ss_rd_en = 1'b1;
                        state_in = ST_FREE_CHK;
                     end
                  end
                  pspa_pkg::REQ_RELEASE: begin
                     open_in  = '0;
                     total_in = '0;
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_status.done) begin
               if (scan_status.found) begin
                  sel_page_in = scan_page;
                  state_in    = ST_POP_RD;
               end else if (open_ff >= OW'(MAX_PAGES)) begin
                  status_in = pspa_pkg::STAT_NO_PAGES;
                  state_in  = ST_DONE;
               end else begin
                  sel_page_in = PW'(open_ff);
                  new_page_in = 1'b1;
                  open_in     = open_ff + OW'(1);
                  state_in    = ST_POP_RD;
               end
            end
         end
         ST_POP_RD: begin
            ss_rd_en   = 1'b1;
            ss_rd_addr = {sel_page_ff, SW'(pop_head)};
            hslot_in   = SW'(pop_head);
            state_in   = ST_POP_WB;
         end
         ST_POP_WB: begin
            ss_wr_en    = 1'b1;
            ss_wr_addr  = {sel_page_ff, hslot_ff};
            ss_wr_used  = 1'b1;
            ss_wr_link  = ss_link;
            pt_wr_en    = 1'b1;
            pt_wr_page  = sel_page_ff;
            pt_wr_head  = ss_link;
            pt_wr_count = ent_count + NW'(1);
            pt_wr_wm    = ss_fresh ? NW'(hslot_ff) + NW'(1) : ent_wm;
            total_in    = total_ff + TW'(1);
            hpage_in    = sel_page_ff;
            state_in    = ST_DONE;
         end
         ST_FREE_CHK: begin
            if (!ss_used) begin
               status_in = pspa_pkg::STAT_DOUBLE_FREE;
            end else begin
               ss_wr_en    = 1'b1;
               ss_wr_addr  = {PW'(req_ff.free_page), SW'(req_ff.free_slot)};
               ss_wr_used  = 1'b0;
               ss_wr_link  = pt_rd_head;
               pt_wr_en    = 1'b1;
               pt_wr_page  = PW'(req_ff.free_page);
               pt_wr_head  = NW'(req_ff.free_slot);
               pt_wr_count = (pt_rd_count != '0) ? pt_rd_count - NW'(1) : '0;
               pt_wr_wm    = pt_rd_wm;
               if (total_ff != '0) begin
                  total_in = total_ff - TW'(1);
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_word_in.handle_page    = pspa_pkg::PAGE_OUT_W'(hpage_ff);
               rsp_word_in.handle_slot    = pspa_pkg::SLOT_OUT_W'(hslot_ff);
               rsp_word_in.status         = status_ff;
               rsp_word_in.objects_in_use = pspa_pkg::OBJ_OUT_W'(total_ff);
               rsp_word_in.pages_open     = pspa_pkg::OPEN_OUT_W'(open_ff);
               rsp_valid_in               = 1'b1;
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         open_ff      <= '0;
         total_ff     <= '0;
         spp_ff       <= pspa_pkg::CSR_W'(256);
         new_page_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         total_ff     <= total_in;
         spp_ff       <= spp_in;
         new_page_ff  <= new_page_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      sel_page_ff <= sel_page_in;
      status_ff   <= status_in;
      hpage_ff    <= hpage_in;
      hslot_ff    <= hslot_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   open_pages_bounded: assert property (@(posedge clock) disable iff (reset)
      open_ff <= OW'(MAX_PAGES))
      else $error("more pages open than the pool holds");

   result_after_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result word raised outside the completion state");

   no_scan_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !scan_status.done)
      else $error("page scan still running while the sequencer is idle");

   popped_slot_in_page: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP_WB) |-> (NW'(hslot_ff) < n_eff))
      else $error("allocated slot lies beyond the page size");

endmodule
